@@ design/ddd_pkg.sv @@
`default_nettype none

package ddd_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned CountW   = 22;
  localparam int unsigned AccW     = 24;
  localparam int unsigned MulAW    = 15;
  localparam int unsigned MulBW    = 13;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned QuotW    = 9;

  // x / 100 == (x * Recip100) >> RecipShift for x below 43699
  localparam logic [MulBW-1:0] Recip100   = 13'd5243;
  localparam int unsigned      RecipShift = 19;
  localparam logic [MulBW-1:0] DaysYear   = 13'd365;

  localparam logic [CountW-1:0] DayCountMax = {CountW{1'b1}};

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // out-of-range months fold onto January or December
  function automatic logic [MonthW-1:0] month_clamp(input logic [MonthW-1:0] m);
    logic [MonthW-1:0] r;
    if (m < MonthJan) begin
      r = MonthJan;
    end else if (m > MonthDec) begin
      r = MonthDec;
    end else begin
      r = m;
    end
    return r;
  endfunction

  // days in a common year before the first of month m (m already clamped)
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/date_difference_days_top.sv @@
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------------------
// in       | in_valid_i / in_ready_o     | first_{year,month,day}_i,
//          |                             | second_{year,month,day}_i
// out      | out_valid_o / out_ready_i   | day_count_o
//
// One request runs from accept to out_valid_o in seven steps per date on the
// shared multiplier and adder, then two steps to form |a - b| + 1.
// in_ready_o rises together with out_valid_o, so requests never overlap.
// in_ready_o is high only while the sequencer is idle; a result held by a stalled
// out_ready_i does not block the next accept, but the final step waits for it.
// rst_ni is asynchronous, active low, and clears the sequencer and out_valid_o.
`default_nettype none

module date_difference_days_top
  import ddd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [YearW-1:0]  first_year_i,
  input  wire logic [MonthW-1:0] first_month_i,
  input  wire logic [DayW-1:0]   first_day_i,
  input  wire logic [YearW-1:0]  second_year_i,
  input  wire logic [MonthW-1:0] second_month_i,
  input  wire logic [DayW-1:0]   second_day_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CountW-1:0]      day_count_o
);

  // Sequencer steps for one date, then the difference. The product register
  // lags the issue by one step, so each quotient is used the step after it
  // is issued:
  //   MUL   issue y*365
  //   BASE  acc = 365y
  //   QUAD  acc += ceil(y/4),       issue (y+99)*R
  //   CENT  acc -= ceil(y/100),     issue ((y+399)>>2)*R
  //   QCENT acc += ceil(y/400),     issue y*R
  //   LEAP  acc += days before month, decide leap from floor(y/100)
  //   DAY   acc += day + leap day
  //   SUB   acc = a - b
  //   FIN   count = |acc| + 1, saturated
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_QUAD,
    ST_CENT,
    ST_QCENT,
    ST_LEAP,
    ST_DAY,
    ST_SUB,
    ST_FIN
  } state_e;

  state_e state_q;

  // request payload
  logic [YearW-1:0]  y1_q, y2_q;
  logic [MonthW-1:0] m1_q, m2_q;
  logic [DayW-1:0]   d1_q, d2_q;
  logic              sel_q;      // 0: first date, 1: second date

  logic [ProdW-1:0]  prod_q;
  logic [AccW-1:0]   acc_q;
  logic [AccW-1:0]   na_q;       // day number of first date
  logic [QuotW-1:0]  c100_q;     // ceil(y/100)
  logic              leap_q;

  logic [YearW-1:0]  cur_y;
  logic [MonthW-1:0] cur_m;
  logic [DayW-1:0]   cur_d;

  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [AccW-1:0]   add_a, add_b, add_sum;
  logic              add_cin;

  logic [QuotW-1:0]  quot;
  logic [MulAW-1:0]  y_p3, y_p99, y_p399;
  logic              in_acc, fin_go, leap_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign fin_go     = !out_valid_o || out_ready_i;

  assign cur_y = sel_q ? y2_q : y1_q;
  assign cur_m = month_clamp(sel_q ? m2_q : m1_q);
  assign cur_d = sel_q ? d2_q : d1_q;

  assign y_p3   = MulAW'(cur_y) + MulAW'(3);
  assign y_p99  = MulAW'(cur_y) + MulAW'(99);
  assign y_p399 = MulAW'(cur_y) + MulAW'(399);

  assign quot = prod_q[ProdW-1:RecipShift];

  // leap: y%4 == 0 and (y not a century, or y/100 divisible by 4)
  assign leap_d = (cur_y[1:0] == 2'b00) && ((c100_q != quot) || (quot[1:0] == 2'b00));

  // operand selection for the shared multiplier and adder
  always_comb begin
    mul_a   = MulAW'(cur_y);
    mul_b   = Recip100;
    add_a   = acc_q;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      ST_MUL: begin
        mul_b = DaysYear;
      end
      ST_BASE: begin
        add_a = '0;
        add_b = AccW'(prod_q[22:0]);
      end
      ST_QUAD: begin
        mul_a = y_p99;
        add_b = AccW'(y_p3[MulAW-1:2]);
      end
      ST_CENT: begin
        mul_a   = MulAW'(y_p399[MulAW-1:2]);
        add_b   = ~AccW'(quot);
        add_cin = 1'b1;
      end
      ST_QCENT: begin
        add_b = AccW'(quot);
      end
      ST_LEAP: begin
        add_b = AccW'(days_before(cur_m));
      end
      ST_DAY: begin
        add_b   = AccW'(cur_d);
        add_cin = (cur_m > MonthFeb) && leap_q;
      end
      ST_SUB: begin
        add_a   = na_q;
        add_b   = ~acc_q;
        add_cin = 1'b1;
      end
      ST_FIN: begin
        // |acc| + 1: for negative acc, ~acc + 2
        add_a   = acc_q[AccW-1] ? ~acc_q : acc_q;
        add_b   = AccW'(acc_q[AccW-1]);
        add_cin = 1'b1;
      end
      ST_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_a + add_b + AccW'(add_cin);

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    if (in_acc) begin
      y1_q <= first_year_i;
      m1_q <= first_month_i;
      d1_q <= first_day_i;
      y2_q <= second_year_i;
      m2_q <= second_month_i;
      d2_q <= second_day_i;
    end
    if (state_q == ST_CENT) begin
      c100_q <= quot;
    end
    if (state_q == ST_LEAP) begin
      leap_q <= leap_d;
    end
    if (state_q == ST_DAY && !sel_q) begin
      na_q <= add_sum;
    end
    if (state_q == ST_BASE || state_q == ST_QUAD || state_q == ST_CENT ||
        state_q == ST_QCENT || state_q == ST_LEAP || state_q == ST_DAY ||
        state_q == ST_SUB) begin
      acc_q <= add_sum;
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      out_valid_o <= 1'b0;
      day_count_o <= '0;
    end else begin
      // in FIN a taken result is replaced by the new one below
      if (out_valid_o && out_ready_i && state_q != ST_FIN) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sel_q   <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL:   state_q <= ST_BASE;
        ST_BASE:  state_q <= ST_QUAD;
        ST_QUAD:  state_q <= ST_CENT;
        ST_CENT:  state_q <= ST_QCENT;
        ST_QCENT: state_q <= ST_LEAP;
        ST_LEAP:  state_q <= ST_DAY;
        ST_DAY: begin
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_SUB;
          end
        end
        ST_SUB:   state_q <= ST_FIN;
        ST_FIN: begin
          if (fin_go) begin
            out_valid_o <= 1'b1;
            day_count_o <= (add_sum[AccW-1:CountW] != '0) ? DayCountMax
                                                           : add_sum[CountW-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/ddd_checker.sv @@
`default_nettype none

module ddd_checker
  import ddd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CountW-1:0] day_count_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(day_count_o))
    else $error("result dropped or changed under stall");

  // inclusive count is never zero
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> day_count_o != '0)
    else $error("zero day count");

  // block is busy right after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // a result cannot appear the cycle after a request is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind date_difference_days_top ddd_checker u_ddd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .day_count_o (day_count_o)
);

`default_nettype wire

@@ dv/date_difference_days_top_tb.sv @@
module date_difference_days_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ddd_pkg::*;

  // Run shape
  localparam int unsigned RandomRequests = 1230;
  localparam int unsigned IdlePercent    = 22;
  localparam int unsigned CalmFrom       = 400;   // no idling on either side in this window
  localparam int unsigned CalmTo         = 650;
  localparam int unsigned HoldoffAt      = 900;   // receiver blocks once, here
  localparam int unsigned HoldoffCycles  = 400;
  localparam int unsigned StallLimit     = 3000;  // cycles without any handshake
  localparam int unsigned DrainCycles    = 40;    // longer than one request's latency
  localparam int unsigned ReportLimit    = 10;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t first;
    date_t second;
  } date_pair_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [YearW-1:0]  first_year_i   = '0;
  logic [MonthW-1:0] first_month_i  = '0;
  logic [DayW-1:0]   first_day_i    = '0;
  logic [YearW-1:0]  second_year_i  = '0;
  logic [MonthW-1:0] second_month_i = '0;
  logic [DayW-1:0]   second_day_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [CountW-1:0] day_count_o;

  date_pair_t        pending_q[$];   // requests not yet offered
  logic [CountW-1:0] count_q[$];     // predicted day counts, oldest first

  int unsigned accepted_cnt  = 0;
  int unsigned checked_cnt   = 0;
  int unsigned saturated_cnt = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned holdoff_left  = 0;
  bit          holdoff_done  = 1'b0;
  int unsigned quiet_cycles  = 0;

  date_difference_days_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_year_i   (first_year_i),
    .first_month_i  (first_month_i),
    .first_day_i    (first_day_i),
    .second_year_i  (second_year_i),
    .second_month_i (second_month_i),
    .second_day_i   (second_day_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .day_count_o    (day_count_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // length of month m in a non-leap year (m in 1..12)
  function automatic int unsigned common_month_len(int unsigned m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return 28;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned month_len(int unsigned y, int unsigned m);
    return common_month_len(m) + ((m == MonthFeb && is_leap_year(y)) ? 1 : 0);
  endfunction

  // Ordinal day counted from Jan 1 of year 0 as day 1. Months fold onto
  // Jan/Dec; the day is added linearly, so day 0 and overlong days spill over.
  function automatic int unsigned ordinal_day(date_t dt);
    int unsigned y;
    int unsigned m;
    int unsigned n;
    y = 32'(dt.year);
    m = 32'(dt.month);
    if (m < MonthJan) m = MonthJan;
    if (m > MonthDec) m = MonthDec;
    // whole years 0..y-1; year 0 itself is a leap year
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++) n += month_len(y, k);
    return n + 32'(dt.day);
  endfunction

  function automatic logic [CountW-1:0] inclusive_span(date_pair_t p);
    int unsigned a;
    int unsigned b;
    int unsigned span;
    a = ordinal_day(p.first);
    b = ordinal_day(p.second);
    span = ((a > b) ? a - b : b - a) + 1;
    if (span > DayCountMax) span = 32'(DayCountMax);
    return span[CountW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  task automatic add_request(int unsigned y1, int unsigned m1, int unsigned d1,
                             int unsigned y2, int unsigned m2, int unsigned d2);
    date_pair_t p;
    p.first  = '{year: YearW'(y1), month: MonthW'(m1), day: DayW'(d1)};
    p.second = '{year: YearW'(y2), month: MonthW'(m2), day: DayW'(d2)};
    pending_q.push_back(p);
  endtask

  function automatic date_t legal_date(int unsigned y);
    date_t dt;
    dt.year  = YearW'(y);
    dt.month = MonthW'($urandom_range(12, 1));
    dt.day   = DayW'($urandom_range(month_len(y, 32'(dt.month)), 1));
    return dt;
  endfunction

  // years around century and quad-century boundaries, where the leap rule bites
  function automatic int unsigned boundary_year();
    int unsigned y;
    y = 100 * $urandom_range(99, 1) + $urandom_range(2) - 1;
    return (y < 1) ? 1 : y;
  endfunction

  function automatic date_t raw_date();
    date_t dt;
    dt.year  = YearW'($urandom_range(16383));
    dt.month = MonthW'($urandom_range(15));
    dt.day   = DayW'($urandom_range(31));
    return dt;
  endfunction

  task automatic add_random_request();
    date_pair_t  p;
    int unsigned pick;
    int unsigned y;
    pick = $urandom_range(99);
    if (pick < 55) begin
      p.first  = legal_date($urandom_range(9999, 1));
      p.second = legal_date($urandom_range(9999, 1));
    end else if (pick < 72) begin
      // close pair: same or adjacent year, catches month/day arithmetic
      y = $urandom_range(9997, 2);
      p.first  = legal_date(y);
      p.second = legal_date(y + $urandom_range(2) - 1);
    end else if (pick < 85) begin
      y = boundary_year();
      p.first  = legal_date(y);
      p.second = legal_date(($urandom_range(1)) ? y : boundary_year());
    end else begin
      // out-of-range fields, year 0 and huge years, saturation
      p.first  = raw_date();
      p.second = raw_date();
    end
    pending_q.push_back(p);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers requests from pending_q, idling at random outside the calm
  // window. Payload only changes once the current request has been taken.
  // ---------------------------------------------------------------------------

  function automatic bit side_idles();
    if (accepted_cnt >= CalmFrom && accepted_cnt < CalmTo) return 1'b0;
    return $urandom_range(99) < IdlePercent;
  endfunction

  always @(posedge clk_i) begin : drive_requests
    date_pair_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_q.size() != 0 && !side_idles()) begin
        p = pending_q.pop_front();
        first_year_i   <= p.first.year;
        first_month_i  <= p.first.month;
        first_day_i    <= p.first.day;
        second_year_i  <= p.second.year;
        second_month_i <= p.second.month;
        second_day_i   <= p.second.day;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: one long block mid-run so the block fills up and
  // drops in_ready_o while the driver keeps offering.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      holdoff_left <= 0;
    end else if (!holdoff_done && accepted_cnt == HoldoffAt) begin
      holdoff_left <= HoldoffCycles;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (holdoff_left == 0) && !side_idles();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted request, checks every accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch_channels
    date_pair_t        p;
    logic [CountW-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        p.first  = '{year: first_year_i, month: first_month_i, day: first_day_i};
        p.second = '{year: second_year_i, month: second_month_i, day: second_day_i};
        count_q.push_back(inclusive_span(p));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (count_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= ReportLimit)
            $display("[%0t] unexpected result: day_count %0d", $realtime, day_count_o);
        end else begin
          want = count_q.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (want == DayCountMax) saturated_cnt <= saturated_cnt + 1;
          if (day_count_o !== want) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= ReportLimit)
              $display("[%0t] day_count mismatch: expected %0d, got %0d",
                       $realtime, want, day_count_o);
          end
        end
      end
    end
  end

  // Watchdog: a hang shows as a long run of cycles without any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // directed: extremes, leap rule, folded months, spilling days, saturation
    add_request(1, 1, 1, 1, 1, 1);              // same date -> 1
    add_request(1, 1, 1, 9999, 12, 31);         // full legal range
    add_request(9999, 12, 31, 1, 1, 1);         // same, reversed order
    add_request(2000, 2, 28, 2000, 3, 1);       // 400-year leap
    add_request(1900, 2, 28, 1900, 3, 1);       // century, not leap
    add_request(2024, 2, 29, 2023, 2, 28);
    add_request(2023, 12, 31, 2024, 1, 1);      // year rollover
    add_request(4, 3, 1, 4, 2, 28);
    add_request(400, 3, 1, 400, 2, 29);
    add_request(100, 3, 1, 100, 2, 28);
    add_request(2020, 0, 15, 2020, 1, 15);      // month 0 folds to January
    add_request(2020, 13, 1, 2020, 12, 1);      // months past 12 fold to December
    add_request(2020, 15, 31, 2020, 14, 31);
    add_request(2021, 3, 0, 2021, 2, 28);       // day 0 is previous month's last
    add_request(2021, 1, 0, 2020, 12, 31);
    add_request(2021, 2, 31, 2021, 3, 3);       // day past month end runs on
    add_request(0, 1, 1, 1, 1, 1);              // year zero
    add_request(0, 0, 0, 0, 0, 0);
    add_request(10000, 1, 1, 9999, 12, 31);     // above nominal range
    add_request(16383, 15, 31, 0, 0, 0);        // saturates
    add_request(16383, 15, 31, 16383, 15, 31);
    add_request(12000, 6, 15, 1, 1, 1);         // just over the count limit
    for (int unsigned i = 0; i < RandomRequests; i++) add_random_request();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (count_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    // predictions never matched by a result count as failures
    mismatch_cnt = mismatch_cnt + count_q.size();

    $display("covered %0d date-pair requests, %0d day counts checked (%0d saturated)",
             accepted_cnt, checked_cnt, saturated_cnt);
    $display("leap rule edges, folded months, spilling days, long stall; %0d failures",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ddd_pkg.sv
design/date_difference_days_top.sv
design/ddd_checker.sv
dv/date_difference_days_top_tb.sv
